// ===== sv/npq_pkg.sv =====
package npq_pkg;

   localparam int PaletteSize     = 16;
   localparam int IndexWidth      = 4;
   localparam int IndicesPerWord  = 8;
   localparam int PosWidth        = 3;
   localparam int AccWidth        = IndexWidth * (IndicesPerWord - 1);
   localparam int WordWidth       = IndexWidth * IndicesPerWord;
   localparam int ChanWidth       = 8;
   localparam int SquareWidth     = 2 * ChanWidth;
   localparam int DistWidth       = SquareWidth + 2;
   localparam int WordCountWidth  = 12;
   localparam int FrameWordsWidth = 13;
   localparam int GroupSize       = 4;
   localparam int GroupCount      = PaletteSize / GroupSize;

   localparam logic [FrameWordsWidth-1:0] FrameWordsReset = 13'd224;
   localparam logic [PosWidth-1:0]        LastPos         = 3'(IndicesPerWord - 1);

   localparam int ExpandScale   = 255;
   localparam int ExpandDivisor = 31;

   // RGB555 palette: red in bits 4:0, green in 9:5, blue in 14:10, bit 15 unused.
   localparam logic [15:0] PalWords [PaletteSize] = '{
      16'h8000, 16'hCE73, 16'hC631, 16'hC210, 16'hBDEF, 16'hB9CE, 16'hB5AD, 16'hB18C,
      16'hA529, 16'hA108, 16'h98C6, 16'h94A5, 16'h9084, 16'h8C63, 16'h8842, 16'h8421
   };

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [WordWidth-1:0] packed_word;
      logic                 last_word;
   } word_type;

   typedef struct packed {
      logic                  valid;
      logic [IndexWidth-1:0] index;
   } idx_item_type;

   // Expands one 5-bit palette channel to 8 bits, rounding down.
   function automatic logic [ChanWidth-1:0] expand5(input logic [15:0] word,
                                                     input int unsigned pos);
      logic [4:0]  chan;
      logic [12:0] prod;
      chan = word[pos +: 5];
      prod = 13'(chan) * 13'(ExpandScale);
      return ChanWidth'(prod / 13'(ExpandDivisor));
   endfunction

endpackage

// ===== sv/npq_front.sv =====
module npq_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  npq_pkg::pixel_type     req_pixel,
   input  logic                   queue_full,
   output npq_pkg::idx_item_type  push
);

   logic                          front_adv;

   logic                          v1_ff, v1_in;
   npq_pkg::pixel_type            pix_ff;

   logic                          v2_ff, v2_in;
   logic [npq_pkg::DistWidth-1:0] dist_ff [npq_pkg::PaletteSize];
   logic [npq_pkg::DistWidth-1:0] dist_in [npq_pkg::PaletteSize];

   logic                          v3_ff, v3_in;
   logic [npq_pkg::DistWidth-1:0] grp_dist_ff [npq_pkg::GroupCount];
   logic [npq_pkg::DistWidth-1:0] grp_dist_in [npq_pkg::GroupCount];
   logic [npq_pkg::IndexWidth-1:0] grp_idx_ff [npq_pkg::GroupCount];
   logic [npq_pkg::IndexWidth-1:0] grp_idx_in [npq_pkg::GroupCount];

   logic                          v4_ff, v4_in;
   logic [npq_pkg::IndexWidth-1:0] idx_ff, idx_in;

   // The whole front moves together; it holds only when its finished index
   // cannot enter the queue.
   assign front_adv = !(v4_ff && queue_full);
   assign req_stall = !front_adv;

   assign v1_in = req_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;
   assign v4_in = v3_ff;

   // Squared distance to every palette entry, one lane per entry.
   always_comb begin
      logic [npq_pkg::ChanWidth-1:0]   pr, pg, pb;
      logic [npq_pkg::ChanWidth-1:0]   dr, dg, db;
      logic [npq_pkg::SquareWidth-1:0] sr, sg, sb;
      for (int i = 0; i < npq_pkg::PaletteSize; i++) begin
         pr = npq_pkg::expand5(npq_pkg::PalWords[i], 0);
         pg = npq_pkg::expand5(npq_pkg::PalWords[i], 5);
         pb = npq_pkg::expand5(npq_pkg::PalWords[i], 10);
         dr = (pix_ff.red   >= pr) ? pix_ff.red   - pr : pr - pix_ff.red;
         dg = (pix_ff.green >= pg) ? pix_ff.green - pg : pg - pix_ff.green;
         db = (pix_ff.blue  >= pb) ? pix_ff.blue  - pb : pb - pix_ff.blue;
         sr = npq_pkg::SquareWidth'(dr) * npq_pkg::SquareWidth'(dr);
         sg = npq_pkg::SquareWidth'(dg) * npq_pkg::SquareWidth'(dg);
         sb = npq_pkg::SquareWidth'(db) * npq_pkg::SquareWidth'(db);
         dist_in[i] = npq_pkg::DistWidth'(sr) + npq_pkg::DistWidth'(sg)
                    + npq_pkg::DistWidth'(sb);
      end
   end

   // First half of the minimum search. Scanning upward with a strict compare
   // keeps the lowest index on a tie.
   always_comb begin
      logic [npq_pkg::DistWidth-1:0] best_d;
      logic [1:0]                    best_i;
      for (int g = 0; g < npq_pkg::GroupCount; g++) begin
         best_d = dist_ff[g*npq_pkg::GroupSize];
         best_i = 2'd0;
         for (int k = 1; k < npq_pkg::GroupSize; k++) begin
            if (dist_ff[g*npq_pkg::GroupSize + k] < best_d) begin
               best_d = dist_ff[g*npq_pkg::GroupSize + k];
               best_i = 2'(k);
            end
         end
         grp_dist_in[g] = best_d;
         grp_idx_in[g]  = {2'(g), best_i};
      end
   end

   always_comb begin
      logic [npq_pkg::DistWidth-1:0] best_d;
      best_d = grp_dist_ff[0];
      idx_in = grp_idx_ff[0];
      for (int g = 1; g < npq_pkg::GroupCount; g++) begin
         if (grp_dist_ff[g] < best_d) begin
            best_d = grp_dist_ff[g];
            idx_in = grp_idx_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (front_adv) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         pix_ff      <= req_pixel;
         dist_ff     <= dist_in;
         grp_dist_ff <= grp_dist_in;
         grp_idx_ff  <= grp_idx_in;
         idx_ff      <= idx_in;
      end
   end

   assign push.valid = v4_ff && !queue_full;
   assign push.index = idx_ff;

   a_held_index_stable: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && queue_full) |=> (v4_ff && $stable(idx_ff)))
      else $error("front lost or changed an index while the queue was full");

endmodule

// ===== sv/npq_queue.sv =====
module npq_queue #(
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  npq_pkg::idx_item_type          push,
   input  logic                           pop,
   output logic                           full,
   output logic                           empty,
   output logic [npq_pkg::IndexWidth-1:0] pop_index
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [npq_pkg::IndexWidth-1:0] mem_ff [DEPTH];
   logic [PtrWidth-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]          count_ff, count_in;

   assign full      = (count_ff == CountWidth'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_index = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.index;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("index pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("index popped from an empty queue");

endmodule

// ===== sv/npq_back.sv =====
module npq_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [npq_pkg::FrameWordsWidth-1:0] frame_words,
   input  logic                                queue_empty,
   input  logic [npq_pkg::IndexWidth-1:0]      pop_index,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output npq_pkg::word_type                   rsp_word
);

   logic [npq_pkg::AccWidth-1:0]        acc_ff, acc_in;
   logic [npq_pkg::PosWidth-1:0]        pos_ff, pos_in;
   logic [npq_pkg::WordCountWidth-1:0]  wcnt_ff, wcnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   npq_pkg::word_type                   rsp_word_ff, rsp_word_in;

   logic                                out_free;
   logic                                completes;
   logic [npq_pkg::FrameWordsWidth-1:0] next_count;
   logic                                last;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // An index that does not finish a word never waits on the output side.
   assign pop        = !queue_empty && ((pos_ff != npq_pkg::LastPos) || out_free);
   assign completes  = pop && (pos_ff == npq_pkg::LastPos);
   assign next_count = {1'b0, wcnt_ff} + 1'b1;
   assign last       = (next_count == frame_words);

   always_comb begin
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      wcnt_in      = wcnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (completes) begin
         acc_in                  = '0;
         pos_in                  = '0;
         wcnt_in                 = last ? '0 : next_count[npq_pkg::WordCountWidth-1:0];
         rsp_valid_in            = 1'b1;
         rsp_word_in.packed_word = {pop_index, acc_ff};
         rsp_word_in.last_word   = last;
      end else if (pop) begin
         for (int n = 0; n < npq_pkg::IndicesPerWord - 1; n++) begin
            if (pos_ff == npq_pkg::PosWidth'(n)) begin
               acc_in[n*npq_pkg::IndexWidth +: npq_pkg::IndexWidth] = pop_index;
            end
         end
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pos_ff       <= '0;
         wcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         wcnt_ff      <= wcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !completes)
      else $error("finished word overwrote a word still waiting");

   a_restart_after_word: assert property (@(posedge clock) disable iff (reset)
      completes |=> (pos_ff == '0 && acc_ff == '0 && rsp_valid_ff))
      else $error("packer did not restart after emitting a word");

endmodule

// ===== sv/nearest_palette_quantize_pack_core.sv =====
// Nearest-color quantizer to a fixed 16-entry palette, packing eight 4-bit
// indices per 32-bit word.
// Input channel: req_valid/req_stall with req_pixel (8-bit red, green, blue).
// A pixel is taken at every edge with req_valid high and req_stall low, one
// per cycle when the output side keeps up.
// Output channel: rsp_valid/rsp_stall with rsp_word. One word leaves after
// every eighth pixel, the first pixel in bits 3:0; last_word marks the final
// word of a frame whose length in words is csr_write_data, written when
// csr_write_enable is high; the user must keep such writes to times when the
// block is idle, as the block itself does not enforce it. Each pixel's index
// passes four front stages (input register, distances, two halves of the
// minimum search), the index queue, then the output register.
// Throughput is one pixel per cycle while req_stall is low, set by the pipelined distance lanes.
// While rsp_stall is high the packer keeps absorbing indices until a word
// is ready behind the waiting one; then the queue fills and req_stall rises.
// Reset empties the pipeline and queue, clears the packer and word count,
// and sets the frame length to 224 words.
module nearest_palette_quantize_pack_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  npq_pkg::pixel_type                  req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output npq_pkg::word_type                   rsp_word,
   input  logic                                csr_write_enable,
   input  logic [npq_pkg::FrameWordsWidth-1:0] csr_write_data
);

   logic [npq_pkg::FrameWordsWidth-1:0] frame_words_ff, frame_words_in;
   npq_pkg::idx_item_type               push;
   logic                                queue_full;
   logic                                queue_empty;
   logic                                pop;
   logic [npq_pkg::IndexWidth-1:0]      pop_index;

   assign frame_words_in = csr_write_enable ? csr_write_data : frame_words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_words_ff <= npq_pkg::FrameWordsReset;
      end else begin
         frame_words_ff <= frame_words_in;
      end
   end

   npq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pixel  (req_pixel),
      .queue_full (queue_full),
      .push       (push)
   );

   npq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .pop_index (pop_index)
   );

   npq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_words (frame_words_ff),
      .queue_empty (queue_empty),
      .pop_index   (pop_index),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule
